// File: src/abeu_pkg.sv
// abeu_pkg: shared types, operation codes and widths for the alu/branch execute unit
// no dependencies

package abeu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned CMD_W = 6;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CMD_W-1:0] OP_NOP = 6'd0;
  localparam logic [CMD_W-1:0] OP_ADD = 6'd1;
  localparam logic [CMD_W-1:0] OP_SUB = 6'd2;
  localparam logic [CMD_W-1:0] OP_MUL = 6'd3;
  localparam logic [CMD_W-1:0] OP_DIVS = 6'd4;
  localparam logic [CMD_W-1:0] OP_DIVU = 6'd5;
  localparam logic [CMD_W-1:0] OP_WMULS = 6'd6;
  localparam logic [CMD_W-1:0] OP_WMULU = 6'd7;
  localparam logic [CMD_W-1:0] OP_DMODS = 6'd8;
  localparam logic [CMD_W-1:0] OP_DMODU = 6'd9;
  localparam logic [CMD_W-1:0] OP_XOR = 6'd10;
  localparam logic [CMD_W-1:0] OP_NEG = 6'd11;
  localparam logic [CMD_W-1:0] OP_REMS = 6'd12;
  localparam logic [CMD_W-1:0] OP_REMU = 6'd13;
  localparam logic [CMD_W-1:0] OP_PASSA = 6'd14;
  localparam logic [CMD_W-1:0] OP_PASSB = 6'd15;
  localparam logic [CMD_W-1:0] OP_SEQ = 6'd16;
  localparam logic [CMD_W-1:0] OP_SGE = 6'd17;
  localparam logic [CMD_W-1:0] OP_SGT = 6'd18;
  localparam logic [CMD_W-1:0] OP_SLE = 6'd19;
  localparam logic [CMD_W-1:0] OP_SLT = 6'd20;
  localparam logic [CMD_W-1:0] OP_SNE = 6'd21;
  localparam logic [CMD_W-1:0] OP_J = 6'd22;
  localparam logic [CMD_W-1:0] OP_JAL = 6'd23;
  localparam logic [CMD_W-1:0] OP_BEQ = 6'd24;
  localparam logic [CMD_W-1:0] OP_BNE = 6'd25;
  localparam logic [CMD_W-1:0] OP_BGE = 6'd26;
  localparam logic [CMD_W-1:0] OP_BLE = 6'd27;
  localparam logic [CMD_W-1:0] OP_BGT = 6'd28;
  localparam logic [CMD_W-1:0] OP_BLT = 6'd29;
  localparam logic [CMD_W-1:0] OP_BEQZ = 6'd30;
  localparam logic [CMD_W-1:0] OP_BNEZ = 6'd31;
  localparam logic [CMD_W-1:0] OP_BLEZ = 6'd32;
  localparam logic [CMD_W-1:0] OP_BGEZ = 6'd33;
  localparam logic [CMD_W-1:0] OP_BGTZ = 6'd34;
  localparam logic [CMD_W-1:0] OP_BLTZ = 6'd35;

  // unit that carries out an item
  typedef enum logic [2:0] {
    UNIT_SIMPLE = 3'b001,
    UNIT_MUL    = 3'b010,
    UNIT_DIV    = 3'b100
  } unit_t;

  // how a divide result is placed
  typedef enum logic [1:0] {
    DSEL_QUO = 2'd0,
    DSEL_BOTH = 2'd1,
    DSEL_REM = 2'd2
  } dsel_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic signed [XLEN-1:0] operand_a;
    logic signed [XLEN-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [XLEN-1:0] result_low;
    logic signed [XLEN-1:0] result_high;
    logic branch_taken;
    logic write_link;
    logic divide_by_zero;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    unit_t            unit;
    logic             sgn;      // signed mul/div
    logic             wide;     // keep high product word
    dsel_t            dsel;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
    out_item_t        simple;   // finished result for simple ops
  } work_t;

endpackage

// File: src/abeu_front.sv
// abeu_front: accepts items, classifies them and resolves simple ops and branches
// depends on abeu_pkg

module abeu_front (
  input  abeu_pkg::in_item_t in_item,
  output abeu_pkg::work_t    work
);

  logic [abeu_pkg::XLEN-1:0] a, b;
  logic eq, lt, gt, az, aneg, apos;

  assign a = in_item.operand_a;
  assign b = in_item.operand_b;
  assign eq = (a == b);
  assign lt = ($signed(a) < $signed(b));
  assign gt = ($signed(b) < $signed(a));
  assign az = (a == '0);
  assign aneg = a[abeu_pkg::XLEN-1];
  assign apos = !aneg && !az;

  always_comb begin
    work = '0;
    work.unit = abeu_pkg::UNIT_SIMPLE;
    work.a = a;
    work.b = b;
    work.dsel = abeu_pkg::DSEL_QUO;
    case (in_item.cmd)
      abeu_pkg::OP_ADD: work.simple.result_low = a + b;
      abeu_pkg::OP_SUB: work.simple.result_low = a - b;
      abeu_pkg::OP_MUL: begin
        work.unit = abeu_pkg::UNIT_MUL;
      end
      abeu_pkg::OP_WMULS: begin
        work.unit = abeu_pkg::UNIT_MUL; work.sgn = 1'b1; work.wide = 1'b1;
      end
      abeu_pkg::OP_WMULU: begin
        work.unit = abeu_pkg::UNIT_MUL; work.wide = 1'b1;
      end
      abeu_pkg::OP_DIVS: begin
        work.unit = abeu_pkg::UNIT_DIV; work.sgn = 1'b1;
      end
      abeu_pkg::OP_DIVU: work.unit = abeu_pkg::UNIT_DIV;
      abeu_pkg::OP_DMODS: begin
        work.unit = abeu_pkg::UNIT_DIV; work.sgn = 1'b1; work.dsel = abeu_pkg::DSEL_BOTH;
      end
      abeu_pkg::OP_DMODU: begin
        work.unit = abeu_pkg::UNIT_DIV; work.dsel = abeu_pkg::DSEL_BOTH;
      end
      abeu_pkg::OP_REMS: begin
        work.unit = abeu_pkg::UNIT_DIV; work.sgn = 1'b1; work.dsel = abeu_pkg::DSEL_REM;
      end
      abeu_pkg::OP_REMU: begin
        work.unit = abeu_pkg::UNIT_DIV; work.dsel = abeu_pkg::DSEL_REM;
      end
      abeu_pkg::OP_XOR: work.simple.result_low = a ^ b;
      abeu_pkg::OP_NEG: work.simple.result_low = '0 - a;
      abeu_pkg::OP_PASSA: work.simple.result_low = a;
      abeu_pkg::OP_PASSB: work.simple.result_low = b;
      abeu_pkg::OP_SEQ: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, eq};
      abeu_pkg::OP_SGE: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, !lt};
      abeu_pkg::OP_SGT: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, gt};
      abeu_pkg::OP_SLE: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, !gt};
      abeu_pkg::OP_SLT: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, lt};
      abeu_pkg::OP_SNE: work.simple.result_low = {{(abeu_pkg::XLEN-1){1'b0}}, !eq};
      abeu_pkg::OP_J: work.simple.branch_taken = 1'b1;
      abeu_pkg::OP_JAL: begin
        work.simple.branch_taken = 1'b1; work.simple.write_link = 1'b1;
      end
      abeu_pkg::OP_BEQ: work.simple.branch_taken = eq;
      abeu_pkg::OP_BNE: work.simple.branch_taken = !eq;
      abeu_pkg::OP_BGE: work.simple.branch_taken = !lt;
      abeu_pkg::OP_BLE: work.simple.branch_taken = !gt;
      abeu_pkg::OP_BGT: work.simple.branch_taken = gt;
      abeu_pkg::OP_BLT: work.simple.branch_taken = lt;
      abeu_pkg::OP_BEQZ: work.simple.branch_taken = az;
      abeu_pkg::OP_BNEZ: work.simple.branch_taken = !az;
      abeu_pkg::OP_BLEZ: work.simple.branch_taken = !apos;
      abeu_pkg::OP_BGEZ: work.simple.branch_taken = !aneg;
      abeu_pkg::OP_BGTZ: work.simple.branch_taken = apos;
      abeu_pkg::OP_BLTZ: work.simple.branch_taken = aneg;
      default: ;
    endcase
  end

endmodule

// File: src/abeu_queue.sv
// abeu_queue: short fifo of classified items between front and back
// depends on abeu_pkg

module abeu_queue #(
  parameter int unsigned DEPTH = abeu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  abeu_pkg::work_t  push_data,
  input  logic             pop,
  output abeu_pkg::work_t  head,
  output logic             empty,
  output logic             full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  abeu_pkg::work_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// File: src/abeu_back.sv
// abeu_back: multiplier and divider pipelines plus ordered retire of all items
// depends on abeu_pkg

module abeu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  abeu_pkg::work_t    in_work,
  output logic               out_strobe,
  output abeu_pkg::out_item_t out_item
);

  localparam int unsigned W = abeu_pkg::XLEN;
  // one quotient bit per stage, plus operand prep and result fix
  localparam int unsigned NST = W + 2;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] quo;   // holds shifting dividend, then quotient bits
    logic [W-1:0] div;
    logic         qneg;
    logic         rneg;
    logic         dz;
    abeu_pkg::unit_t unit;
    logic         wide;
    abeu_pkg::dsel_t dsel;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         sgn;
    logic [2*W-1:0] acc;
    abeu_pkg::out_item_t simple;
  } stg_t;

  stg_t   st_r  [NST];
  logic   vld_r [NST];
  stg_t   st_nxt [NST];

  // every item goes through the same fixed-length pipe so results stay in order
  always_comb begin
    logic [W-1:0] ma, mb;
    logic [W:0] trial;
    logic [2*W-1:0] prod;
    logic [W-1:0] corr;
    logic [W-1:0] q, r;
    for (int i = 0; i < NST; i++) st_nxt[i] = '0;
    // stage 0: magnitudes for division
    st_nxt[0].unit = in_work.unit;
    st_nxt[0].wide = in_work.wide;
    st_nxt[0].dsel = in_work.dsel;
    st_nxt[0].sgn = in_work.sgn;
    st_nxt[0].a = in_work.a;
    st_nxt[0].b = in_work.b;
    st_nxt[0].simple = in_work.simple;
    ma = (in_work.sgn && in_work.a[W-1]) ? '0 - in_work.a : in_work.a;
    mb = (in_work.sgn && in_work.b[W-1]) ? '0 - in_work.b : in_work.b;
    st_nxt[0].quo = ma;
    st_nxt[0].div = mb;
    st_nxt[0].qneg = in_work.sgn && (in_work.a[W-1] != in_work.b[W-1]);
    st_nxt[0].rneg = in_work.sgn && in_work.a[W-1];
    st_nxt[0].dz = (in_work.b == '0);
    // stage 1: unsigned 32x32 product of the registered operands
    prod = {{W{1'b0}}, st_r[0].a} * {{W{1'b0}}, st_r[0].b};
    // restoring divide, one bit per stage
    for (int i = 1; i < NST-1; i++) begin
      st_nxt[i] = st_r[i-1];
      trial = {st_r[i-1].rem, st_r[i-1].quo[W-1]} - {1'b0, st_r[i-1].div};
      if (!trial[W]) begin
        st_nxt[i].rem = trial[W-1:0];
        st_nxt[i].quo = {st_r[i-1].quo[W-2:0], 1'b1};
      end else begin
        st_nxt[i].rem = {st_r[i-1].rem[W-2:0], st_r[i-1].quo[W-1]};
        st_nxt[i].quo = {st_r[i-1].quo[W-2:0], 1'b0};
      end
    end
    st_nxt[1].acc = prod;
    // stage 2: high word fix-up for a signed product
    corr = (st_r[1].a[W-1] ? st_r[1].b : '0) + (st_r[1].b[W-1] ? st_r[1].a : '0);
    if (st_r[1].sgn) st_nxt[2].acc[2*W-1:W] = st_r[1].acc[2*W-1:W] - corr;
    // last stage: signs and result placement
    st_nxt[NST-1] = st_r[NST-2];
    q = st_r[NST-2].qneg ? '0 - st_r[NST-2].quo : st_r[NST-2].quo;
    r = st_r[NST-2].rneg ? '0 - st_r[NST-2].rem : st_r[NST-2].rem;
    st_nxt[NST-1].simple = st_r[NST-2].simple;
    case (st_r[NST-2].unit)
      abeu_pkg::UNIT_MUL: begin
        st_nxt[NST-1].simple = '0;
        st_nxt[NST-1].simple.result_low = st_r[NST-2].acc[W-1:0];
        if (st_r[NST-2].wide) st_nxt[NST-1].simple.result_high = st_r[NST-2].acc[2*W-1:W];
      end
      abeu_pkg::UNIT_DIV: begin
        st_nxt[NST-1].simple = '0;
        if (st_r[NST-2].dz) begin
          st_nxt[NST-1].simple.divide_by_zero = 1'b1;
        end else begin
          case (st_r[NST-2].dsel)
            abeu_pkg::DSEL_QUO: st_nxt[NST-1].simple.result_low = q;
            abeu_pkg::DSEL_BOTH: begin
              st_nxt[NST-1].simple.result_low = q;
              st_nxt[NST-1].simple.result_high = r;
            end
            default: st_nxt[NST-1].simple.result_low = r;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) st_r[i] <= st_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_strobe = vld_r[NST-1];
  assign out_item = st_r[NST-1].simple;

endmodule

// File: src/alu_branch_execute_unit_core.sv
// alu_branch_execute_unit_core: top level, front classifier, queue and execute pipeline
// depends on abeu_pkg, abeu_front, abeu_queue, abeu_back
//
// channel | ports                        | handshake
// input   | start, busy, in_item         | taken when start && !busy
// result  | out_strobe, out_item         | one cycle per result, no back-pressure
//
// one item per cycle while busy is low; an item is written into the queue at its accept
// edge, then moves on into the back end: operand prep, 32 bit-per-stage divider
// stages (the product is formed and fixed up in the first two) and a result stage.
// its result is driven onto the ports from the result stage register.
// the back end never stalls, so busy stays low in normal use.
// synchronous active-low reset clears all valid state.

module alu_branch_execute_unit_core #(
  parameter int unsigned QDEPTH = abeu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  abeu_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output abeu_pkg::out_item_t out_item
);

  abeu_pkg::work_t work, head;
  logic empty, full, push, pop;

  assign busy = full;
  assign push = start && !busy;
  assign pop  = !empty;

  abeu_front u_front (.in_item(in_item), .work(work));

  abeu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(work),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  abeu_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(pop), .in_work(head),
    .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

// File: src/abeu_checker.sv
// abeu_checker: port-level assertions for the execute unit
// depends on abeu_pkg and alu_branch_execute_unit_core

module abeu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input abeu_pkg::out_item_t out_item,
  input logic out_strobe
);

  // no result during or right after reset
  a_no_out_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result during reset");
  // divide flag only with zero words
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.divide_by_zero) |->
    (out_item.result_low == '0 && out_item.result_high == '0))
    else $error("dz with data");
  // link implies taken
  a_link_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.write_link) |-> out_item.branch_taken)
    else $error("link without take");
  // busy never set with an empty pipe right after reset
  a_busy_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

endmodule

bind alu_branch_execute_unit_core abeu_checker u_abeu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_item(out_item), .out_strobe(out_strobe)
);
